// ===== rtl/core/lkvt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lkvt_pkg;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_READ   = 2'd1,
    OP_WRITE  = 2'd2,
    OP_DELETE = 2'd3
  } op_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    op_e         op;
    logic [31:0] key;
    logic [31:0] value;
  } req_t;

  typedef struct packed {
    logic [31:0] read_value;
    logic        found;
    logic        full_drop;
    logic        is_empty;
    logic [4:0]  count_after;
  } rsp_t;

  typedef struct packed {
    logic del_en;
    logic wr_en;
    logic ins_en;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/lkvt_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lkvt_cell import lkvt_pkg::*; #(
  parameter int unsigned KeyWidth   = 32,
  parameter int unsigned ValueWidth = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  occupied_i,
  input  wire logic                  tail_i,
  input  wire cell_ctrl_t            ctrl_i,
  input  wire logic [KeyWidth-1:0]   req_key_i,
  input  wire logic [ValueWidth-1:0] wr_value_i,
  input  wire logic [ValueWidth-1:0] ins_value_i,
  input  wire logic [KeyWidth-1:0]   nxt_key_i,
  input  wire logic [ValueWidth-1:0] nxt_value_i,
  input  wire logic                  hit_i,
  input  wire logic [ValueWidth-1:0] sel_value_i,
  output logic [KeyWidth-1:0]        key_o,
  output logic [ValueWidth-1:0]      value_o,
  output logic                       hit_o,
  output logic [ValueWidth-1:0]      sel_value_o
);

  logic [KeyWidth-1:0]   key_q, key_d;
  logic [ValueWidth-1:0] value_q, value_d;
  logic                  match;
  logic                  first;

  assign match       = occupied_i && (key_q == req_key_i);
  assign first       = match && !hit_i;
  assign hit_o       = hit_i || match;
  assign sel_value_o = first ? value_q : sel_value_i;
  assign key_o       = key_q;
  assign value_o     = value_q;

  always_comb begin
    key_d   = key_q;
    value_d = value_q;
    if (ctrl_i.del_en && hit_o) begin
      // close the gap: take the neighbour's entry
      key_d   = nxt_key_i;
      value_d = nxt_value_i;
    end else if (ctrl_i.wr_en && first) begin
      value_d = wr_value_i;
    end else if (ctrl_i.ins_en && tail_i) begin
      key_d   = req_key_i;
      value_d = ins_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    value_q <= value_d;
  end

endmodule

`default_nettype wire

// ===== rtl/core/linear_key_value_table_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Fixed-depth key/value table kept in insertion order, built as a row of DEPTH
// cells that each hold one entry. A request is registered when taken, resolved
// in EXEC: every cell compares its key at once, a hit flag ripples along
// the row to pick the oldest match, and on commit the cells append, overwrite,
// or shift down by one to close the gap of a delete. A new request is taken only
// once the last commits; commits wait while the output register holds an
// untaken response. Inserts into a full table are dropped, flagged in full_drop.

module linear_key_value_table_unit import lkvt_pkg::*; #(
  parameter int unsigned DEPTH       = 16,
  parameter int unsigned KEY_WIDTH   = 32,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire req_t in_req_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output rsp_t      out_rsp_o
);

  localparam int unsigned CntWidth = $clog2(DEPTH + 1);

  state_e                state_q, state_d;
  req_t                  req_q;
  rsp_t                  rsp_q, rsp_d;
  logic                  out_valid_q, out_valid_d;
  logic [CntWidth-1:0]   count_q, count_d;
  logic                  commit;
  logic                  full;
  logic                  found;
  logic [KEY_WIDTH-1:0]  req_key;
  logic [VALUE_WIDTH-1:0] req_value;
  logic [VALUE_WIDTH-1:0] ins_value;
  logic [VALUE_WIDTH-1:0] hit_value;
  logic [VALUE_WIDTH-1:0] rv;
  logic                  drop;
  logic                  ins_need;
  cell_ctrl_t            ctrl;
  logic [63:0]           key_ext;
  logic [63:0]           val_ext;
  logic [63:0]           rv_ext;
  logic [31:0]           cnt_ext;

  logic [KEY_WIDTH-1:0]   cell_key   [DEPTH];
  logic [VALUE_WIDTH-1:0] cell_value [DEPTH];
  logic                   hit_chain  [DEPTH+1];
  logic [VALUE_WIDTH-1:0] sel_chain  [DEPTH+1];

  assign key_ext   = {32'd0, req_q.key};
  assign val_ext   = {32'd0, req_q.value};
  assign req_key   = key_ext[KEY_WIDTH-1:0];
  assign req_value = val_ext[VALUE_WIDTH-1:0];

  assign hit_chain[0] = 1'b0;
  assign sel_chain[0] = '0;
  assign found        = hit_chain[DEPTH];
  assign hit_value    = sel_chain[DEPTH];
  assign full         = (count_q == CntWidth'(DEPTH));

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_WIDTH-1:0]   nxt_key;
    logic [VALUE_WIDTH-1:0] nxt_value;
    if (i < DEPTH - 1) begin : g_mid
      assign nxt_key   = cell_key[i+1];
      assign nxt_value = cell_value[i+1];
    end else begin : g_last
      assign nxt_key   = cell_key[i];
      assign nxt_value = cell_value[i];
    end

    lkvt_cell #(
      .KeyWidth  (KEY_WIDTH),
      .ValueWidth(VALUE_WIDTH)
    ) u_cell (
      .clk_i      (clk_i),
      .occupied_i (CntWidth'(i) < count_q),
      .tail_i     (CntWidth'(i) == count_q),
      .ctrl_i     (ctrl),
      .req_key_i  (req_key),
      .wr_value_i (req_value),
      .ins_value_i(ins_value),
      .nxt_key_i  (nxt_key),
      .nxt_value_i(nxt_value),
      .hit_i      (hit_chain[i]),
      .sel_value_i(sel_chain[i]),
      .key_o      (cell_key[i]),
      .value_o    (cell_value[i]),
      .hit_o      (hit_chain[i+1]),
      .sel_value_o(sel_chain[i+1])
    );
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o = 1'b0;
    commit     = 1'b0;
    unique case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_EXEC: commit     = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  // resolve the request against the row
  always_comb begin
    ins_need  = 1'b0;
    ins_value = req_value;
    rv        = '0;
    drop      = 1'b0;
    ctrl      = '0;
    count_d   = count_q;
    case (req_q.op)
      OP_ADD: begin
        ins_need = 1'b1;
        rv       = full ? '0 : req_value;
      end
      OP_READ: begin
        ins_value = '0;
        if (found) begin
          rv = hit_value;
        end else begin
          ins_need = 1'b1;
        end
      end
      OP_WRITE: begin
        if (found) begin
          rv        = req_value;
          ctrl.wr_en = commit;
        end else begin
          ins_need = 1'b1;
          rv       = full ? '0 : req_value;
        end
      end
      default: begin
        if (found) begin
          rv          = hit_value;
          ctrl.del_en = commit;
          count_d     = count_q - CntWidth'(1);
        end
      end
    endcase
    if (ins_need) begin
      drop = full;
      if (!full) begin
        ctrl.ins_en = commit;
        count_d     = count_q + CntWidth'(1);
      end
    end
  end

  assign rv_ext  = 64'(rv);
  assign cnt_ext = 32'(count_d);

  always_comb begin
    rsp_d.read_value  = rv_ext[31:0];
    rsp_d.found       = found;
    rsp_d.full_drop   = drop;
    rsp_d.is_empty    = (count_d == '0);
    rsp_d.count_after = cnt_ext[4:0];
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (commit) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q <= in_req_i;
    end
    if (commit) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

endmodule

`default_nettype wire
